// ----- rtl/swrm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_pkg
// Types, codes and constants shared by the sliding window rate meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int MS_SCALE_W     = 18;      // 256000 fits in 18 bits
  localparam int NUM_W_DEF      = $clog2(RING_DEPTH_DEF + 1) + MS_SCALE_W;
  localparam int RATE_MS_SCALE  = 256000;  // 1000 ms per second times q8 scale
  localparam int MS_PER_S       = 1000;
  localparam int BIG_BURST      = 25;
  localparam int WIN_S_W        = 6;
  localparam int WIN_MS_W       = 16;
  localparam int EVENTS_W       = 11;
  localparam int ADDR_W         = 3;

  localparam logic [WIN_S_W-1:0] WINDOW_RESET = 6'd5;
  localparam logic [0:0]         REG_WINDOW   = 1'b0;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
  } swrm_in_t;

  typedef struct packed {
    logic [31:0]         rate_q8;
    logic [EVENTS_W-1:0] events_in_window;
  } swrm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_EMIT_RATE,
    ST_EMIT_ZERO
  } swrm_state_t;

  typedef struct packed {
    logic rec;
    logic clr;
    logic query;
    logic scan;
    logic prep;
    logic div_start;
    logic load_rate;
    logic load_zero;
  } swrm_cmd_t;

  typedef struct packed {
    logic few;
    logic hit;
    logic exhausted;
    logic div_busy;
  } swrm_sts_t;

endpackage : swrm_pkg
`default_nettype wire

// ----- rtl/swrm_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_div
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// ----------------------------------------------------------------------------
module swrm_div import swrm_pkg::*; #(
  parameter int NUM_W = NUM_W_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [31:0]      den,
  output logic                  busy,
  output logic [31:0]           quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [31:0]      den_r;
  logic [32:0]      shifted;
  logic             ge;
  logic             ovf;
  logic [31:0]      q32;

  assign busy = (cnt_r != '0);

  always_comb begin
    shifted = {rem_r, q_r[NUM_W-1]};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? 32'(shifted - {1'b0, den_r}) : shifted[31:0];
    q_nxt   = {q_r[NUM_W-2:0], ge};
    if (start) begin
      cnt_nxt = CW'(NUM_W);
    end else if (busy) begin
      cnt_nxt = cnt_r - CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  generate
    if (NUM_W > 32) begin : g_wide
      assign ovf = |q_r[NUM_W-1:32];
      assign q32 = q_r[31:0];
    end else begin : g_narrow
      assign ovf = 1'b0;
      assign q32 = 32'(q_r);
    end
  endgenerate

  // zero divisor saturates as well
  assign quot = ((den_r == '0) || ovf) ? '1 : q32;

endmodule : swrm_div
`default_nettype wire

// ----- rtl/swrm_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_datapath
// Timestamp ring memory, window scan, rate operand setup and result register.
// ----------------------------------------------------------------------------
module swrm_datapath import swrm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire swrm_cmd_t          cmd,
  output swrm_sts_t               sts,
  input  wire swrm_in_t           in_data,
  input  wire logic [WIN_S_W-1:0] window,
  output swrm_out_t               out_data
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int NUM_W = CNT_W + MS_SCALE_W;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(RING_DEPTH);

  logic [31:0] mem [RING_DEPTH];

  logic [AW-1:0]       oldest_r, oldest_nxt, oldest_inc;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                pend_r, pend_nxt;
  logic [CNT_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [31:0]         rd_data_r;
  logic [31:0]         now_r;
  logic [WIN_MS_W-1:0] win_ms_r;
  logic [CNT_W-1:0]    fcnt_r;
  logic                first_r;
  logic [31:0]         age_r;
  logic [NUM_W-1:0]    num_r, num_val;
  logic [31:0]         den_r, den_val;
  swrm_out_t           out_data_r;

  logic [SUM_W-1:0] wsum, ssum;
  logic [AW-1:0]    wslot, raddr;
  logic             full, issue, fits_win;
  logic [31:0]      age;
  logic             big;
  logic [CNT_W-1:0] cm1;
  logic             div_busy;
  logic [31:0]      quot;

  // ring addressing, wrap without a modulo
  always_comb begin
    wsum       = SUM_W'(oldest_r) + SUM_W'(count_r);
    wslot      = (wsum >= DEPTH_S) ? AW'(wsum - DEPTH_S) : AW'(wsum);
    ssum       = SUM_W'(oldest_r) + SUM_W'(scan_idx_r);
    raddr      = (ssum >= DEPTH_S) ? AW'(ssum - DEPTH_S) : AW'(ssum);
    full       = (count_r == CNT_W'(RING_DEPTH));
    oldest_inc = (oldest_r == AW'(RING_DEPTH - 1)) ? '0 : oldest_r + AW'(1);
  end

  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    if (cmd.rec) begin
      if (full) begin
        oldest_nxt = oldest_inc;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
    if (cmd.clr) begin
      oldest_nxt = '0;
      count_nxt  = '0;
    end
  end

  // scan: issue one read per cycle, compare each entry once its read data is registered
  always_comb begin
    issue        = cmd.scan && (scan_idx_r < count_r);
    pend_idx_nxt = issue ? scan_idx_r : pend_idx_r;
    if (cmd.query) begin
      pend_nxt     = 1'b0;
      scan_idx_nxt = '0;
    end else if (cmd.scan) begin
      pend_nxt     = issue;
      scan_idx_nxt = issue ? scan_idx_r + CNT_W'(1) : scan_idx_r;
    end else begin
      pend_nxt     = pend_r;
      scan_idx_nxt = scan_idx_r;
    end
  end

  always_comb begin
    age      = now_r - rd_data_r;
    fits_win = (age <= {{(32 - WIN_MS_W){1'b0}}, win_ms_r});
    sts.few       = (count_r < CNT_W'(2));
    sts.hit       = pend_r && fits_win;
    sts.exhausted = pend_r && !fits_win && (pend_idx_r == count_r - CNT_W'(1));
    sts.div_busy  = div_busy;
  end

  // operand setup for the three rate rules
  always_comb begin
    big     = first_r && (32'(fcnt_r) > BIG_BURST);
    cm1     = first_r ? fcnt_r - CNT_W'(1) : fcnt_r;
    num_val = big ? NUM_W'(cm1) * NUM_W'(RATE_MS_SCALE) : NUM_W'({cm1, 8'b0});
    den_val = big ? age_r : 32'(window);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      pend_r   <= 1'b0;
    end else begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec) begin
      mem[wslot] <= in_data.now_ms;
    end
    if (issue) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (cmd.query) begin
      now_r    <= in_data.now_ms;
      win_ms_r <= WIN_MS_W'(window) * WIN_MS_W'(MS_PER_S);
    end
    if (cmd.scan && sts.hit) begin
      fcnt_r  <= count_r - pend_idx_r;
      first_r <= (pend_idx_r == '0);
      age_r   <= age;
    end
    if (cmd.prep) begin
      num_r <= num_val;
      den_r <= den_val;
    end
    if (cmd.load_rate) begin
      out_data_r.rate_q8          <= quot;
      out_data_r.events_in_window <= EVENTS_W'(fcnt_r);
    end else if (cmd.load_zero) begin
      out_data_r <= '0;
    end
  end

  assign out_data = out_data_r;

  swrm_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .busy  (div_busy),
    .quot  (quot)
  );

endmodule : swrm_datapath
`default_nettype wire

// ----- rtl/swrm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_ctrl
// Command decode and sequencing of scan, divide and result transfer.
// ----------------------------------------------------------------------------
module swrm_ctrl import swrm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  output logic            out_valid,
  input  wire logic       out_ready,
  output swrm_cmd_t       cmd,
  input  wire swrm_sts_t  sts
);

  swrm_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_command)
            CMD_RECORD: cmd.rec = 1'b1;
            CMD_CLEAR:  cmd.clr = 1'b1;
            CMD_QUERY: begin
              cmd.query = 1'b1;
              state_nxt = sts.few ? ST_EMIT_ZERO : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_PREP;
        end else if (sts.exhausted) begin
          state_nxt = ST_EMIT_ZERO;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_EMIT_RATE;
        end
      end
      ST_EMIT_RATE: begin
        if (out_free) begin
          cmd.load_rate = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EMIT_ZERO: begin
        if (out_free) begin
          cmd.load_zero = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.load_rate || cmd.load_zero) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule : swrm_ctrl
`default_nettype wire

// ----- rtl/sliding_window_event_rate_meter.sv -----
// ----------------------------------------------------------------------------
// sliding_window_event_rate_meter
// Record and clear are taken with no stall; the next item is taken the cycle after.
// A query of two or more entries scans the ring from the oldest, up to RING_DEPTH
// entries, one read per cycle; a hit runs a 29-step serial divider (default depth).
// Synchronous active-low reset empties the ring and sets the window to 5 s.
// ----------------------------------------------------------------------------
`default_nettype none
module sliding_window_event_rate_meter import swrm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire swrm_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output swrm_out_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [WIN_S_W-1:0] window_r, window_nxt;
  logic [0:0]         reg_sel;
  logic               cfg_wr;
  swrm_cmd_t          cmd;
  swrm_sts_t          sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_sel == REG_WINDOW) ? 32'(window_r) : '0;

  always_comb begin
    window_nxt = window_r;
    if (cfg_wr && (reg_sel == REG_WINDOW)) begin
      window_nxt = pwdata[WIN_S_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  swrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  swrm_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .window   (window_r),
    .out_data (out_data)
  );

endmodule : sliding_window_event_rate_meter
`default_nettype wire

// ----- rtl/swrm_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_checker
// Port-level checks of the rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module swrm_checker import swrm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire swrm_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire swrm_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // a query keeps the input side busy for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command == CMD_QUERY) |=> !in_ready)
    else $error("input taken right after a query");

  // record and clear leave the input ready in the next cycle
  a_rec_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    ((in_data.command == CMD_RECORD) || (in_data.command == CMD_CLEAR))
    |=> in_ready)
    else $error("record or clear stalled the input");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule : swrm_checker

bind sliding_window_event_rate_meter swrm_checker u_chk (.*);
`default_nettype wire

// ----- tb/sv/rate_meter_checker.sv -----
// ----------------------------------------------------------------------------
// rate_meter_checker
// Watches the event, result and register ports of the rate meter. Keeps its
// own copy of the timestamp ring and the window setting, works out the rate
// for every accepted query and compares it with the results in order.
// ----------------------------------------------------------------------------
module rate_meter_checker import swrm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  swrm_in_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  swrm_out_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output int unsigned         mismatches,
  output int unsigned         backlog
);

  localparam int Q8_ONE = 256;

  logic [31:0]        stamp_ring [RING_DEPTH_DEF];
  int unsigned        ring_head = 0;
  int unsigned        ring_fill = 0;
  logic [WIN_S_W-1:0] window_s = WINDOW_RESET;
  swrm_out_t          rates_due [$];
  swrm_out_t          want;
  int unsigned        fail_count = 0;

  // first entry from the oldest whose modular age fits the window decides the rate
  function automatic swrm_out_t window_rate(input logic [31:0] now);
    swrm_out_t   res;
    logic [31:0] span;
    logic [31:0] age;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    int unsigned i;
    int unsigned cnt;
    bit          hit;
    res = '0;
    hit = 1'b0;
    i = 0;
    span = window_s * MS_PER_S;
    if (ring_fill >= 2) begin
      while (!hit && i < ring_fill) begin
        age = now - stamp_ring[(ring_head + i) % RING_DEPTH_DEF];
        if (age <= span) begin
          hit = 1'b1;
          cnt = ring_fill - i;
          if (i == 0 && cnt > BIG_BURST) begin
            num = 64'((cnt - 1) * RATE_MS_SCALE);
            den = 64'(age);
          end else if (i == 0) begin
            num = 64'((cnt - 1) * Q8_ONE);
            den = 64'(window_s);
          end else begin
            num = 64'(cnt * Q8_ONE);
            den = 64'(window_s);
          end
          // zero divisor and overflow both pin the rate at full scale
          quo = (den == 0) ? '1 : num / den;
          res.rate_q8 = (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
          res.events_in_window = cnt[EVENTS_W-1:0];
        end
        i++;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ring_head = 0;
      ring_fill = 0;
      window_s = WINDOW_RESET;
      rates_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_WINDOW, 2'b00})
        window_s = pwdata[WIN_S_W-1:0];

      if (out_valid && out_ready) begin
        if (rates_due.size() == 0) begin
          fail_count++;
          $error("result with no query waiting: rate_q8 %0d, events_in_window %0d",
                 out_data.rate_q8, out_data.events_in_window);
        end else begin
          want = rates_due.pop_front();
          if (out_data.rate_q8 !== want.rate_q8) begin
            fail_count++;
            $error("rate_q8 mismatch: expected %0d, actual %0d",
                   want.rate_q8, out_data.rate_q8);
          end
          if (out_data.events_in_window !== want.events_in_window) begin
            fail_count++;
            $error("events_in_window mismatch: expected %0d, actual %0d",
                   want.events_in_window, out_data.events_in_window);
          end
        end
      end

      if (in_valid && in_ready) begin
        case (in_data.command)
          CMD_RECORD: begin
            stamp_ring[(ring_head + ring_fill) % RING_DEPTH_DEF] = in_data.now_ms;
            if (ring_fill == RING_DEPTH_DEF)
              ring_head = (ring_head + 1) % RING_DEPTH_DEF;
            else
              ring_fill++;
          end
          CMD_CLEAR: begin
            ring_head = 0;
            ring_fill = 0;
          end
          CMD_QUERY: rates_due = {rates_due, window_rate(in_data.now_ms)};
          default: ;  // spare code leaves everything alone
        endcase
      end
    end
    backlog <= rates_due.size();
    mismatches <= fail_count;
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the sliding window rate meter with record, query and clear commands:
// a directed opening and randomized phases under several window settings,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import swrm_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 2000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  swrm_in_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  swrm_out_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned         mismatches;
  int unsigned         backlog;
  int unsigned         cycle_count = 0;
  int unsigned         items_sent = 0;
  bit                  in_gaps = 1'b1;
  bit                  out_stalls = 1'b1;
  bit                  hold_request = 1'b0;
  logic [31:0]         clock_ms = '0;
  logic [WIN_S_W-1:0]  win_s = WINDOW_RESET;
  logic [WIN_S_W-1:0]  win_plan [8] = '{6'd1, 6'd60, 6'd0, 6'd63, 6'd2, 6'd10, 6'd30, 6'd5};

  sliding_window_event_rate_meter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  rate_meter_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** sliding_window_event_rate_meter: FAILED **");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (out_stalls && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic [1:0] cmd, input logic [31:0] stamp);
    swrm_in_t item;
    item.command = cmd;
    item.now_ms = stamp;
    @(negedge clk);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd != CMD_UNUSED)
      items_sent++;
  endtask

  // stop offering, wait for every query result, then let the block go quiet
  task automatic settle(input int unsigned quiet);
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_S_W-1:0] secs);
    logic [31:0] word;
    word = $urandom;
    word[WIN_S_W-1:0] = secs;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_WINDOW, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    win_s = secs;
  endtask

  // mostly small forward steps, some repeats of the same ms, jumps and steps back
  task automatic step_clock();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      clock_ms += $urandom_range(0, 400);
    else if (pick >= 72 && pick < 87)
      clock_ms += $urandom_range(0, win_s * 1000 + 1500);
    else if (pick >= 87 && pick < 94)
      clock_ms -= $urandom_range(1, 3000);
    else if (pick >= 94)
      clock_ms += $urandom;
  endtask

  initial begin : stimulus
    logic [31:0] base;
    int unsigned phase;
    int unsigned goal;
    int unsigned pick;
    bit          last;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty and single-entry rings, 32-bit wrap, stale and future stamps
    base = 32'hFFFF_F000;
    offer(CMD_QUERY, base);
    offer(CMD_RECORD, base);
    offer(CMD_QUERY, base);
    offer(CMD_RECORD, base + 1500);
    offer(CMD_RECORD, base + 3000);
    offer(CMD_RECORD, base + 4500);
    offer(CMD_QUERY, base + 4500);
    offer(CMD_QUERY, base + 6000);
    offer(CMD_UNUSED, $urandom);
    offer(CMD_RECORD, base + 100000);
    offer(CMD_QUERY, base + 6000);
    offer(CMD_QUERY, base + 120000);
    offer(CMD_CLEAR, $urandom);
    offer(CMD_QUERY, base);
    offer(CMD_RECORD, 32'h0000_0000);
    offer(CMD_RECORD, 32'hFFFF_FFFF);
    offer(CMD_QUERY, 32'hFFFF_FFFF);
    offer(CMD_QUERY, 32'h0000_0000);

    // zero-second window: only same-ms stamps count, division saturates
    settle(8);
    write_window(6'd0);
    offer(CMD_CLEAR, base);
    offer(CMD_RECORD, base);
    offer(CMD_RECORD, base);
    offer(CMD_QUERY, base);
    offer(CMD_QUERY, base + 1);
    offer(CMD_RECORD, base + 1);
    offer(CMD_QUERY, base + 1);
    offer(CMD_CLEAR, base);
    clock_ms = $urandom;

    win_plan[7] = 6'($urandom_range(0, 63));
    for (phase = 0; phase < 8; phase++) begin
      settle(8);
      write_window(win_plan[phase]);
      last = (phase == 7);
      goal = items_sent + 40;
      if (phase == 1) begin
        // long result hold while queries keep coming, so the input backs up
        hold_request = 1'b1;
        repeat (6) begin
          step_clock();
          offer(CMD_RECORD, clock_ms);
          offer(CMD_QUERY, clock_ms);
        end
      end
      while (items_sent < goal) begin
        in_gaps = !last && $urandom_range(0, 2) != 0;
        out_stalls = !last && $urandom_range(0, 2) != 0;
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          repeat ($urandom_range(2, 20)) begin
            step_clock();
            offer(CMD_RECORD, clock_ms);
          end
          repeat ($urandom_range(1, 2)) begin
            step_clock();
            offer(CMD_QUERY, clock_ms);
          end
        end else if (pick < 11) begin
          // big burst at one ms: zero elapsed, then a short elapsed time
          offer(CMD_CLEAR, clock_ms);
          repeat ($urandom_range(BIG_BURST + 1, 40)) offer(CMD_RECORD, clock_ms);
          offer(CMD_QUERY, clock_ms);
          offer(CMD_QUERY, clock_ms + $urandom_range(1, win_s * 1000));
        end else if (pick < 13) begin
          offer(CMD_CLEAR, clock_ms);
          if ($urandom_range(0, 1) != 0)
            offer(CMD_RECORD, clock_ms);
          offer(CMD_QUERY, clock_ms);
        end else if (pick < 15) begin
          clock_ms += win_s * 1000 + $urandom_range(1, 100000);
          offer(CMD_QUERY, clock_ms);
        end else if (pick < 18) begin
          repeat ($urandom_range(1, 4)) offer(2'($urandom_range(0, 3)), $urandom);
        end else begin
          offer(CMD_RECORD, clock_ms + $urandom_range(1, 50000));
          offer(CMD_QUERY, clock_ms);
        end
      end
    end

    settle(64);
    if (mismatches == 0 && backlog == 0)
      $display("** sliding_window_event_rate_meter: PASSED **");
    else
      $display("** sliding_window_event_rate_meter: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/swrm_pkg.sv
rtl/swrm_div.sv
rtl/swrm_datapath.sv
rtl/swrm_ctrl.sv
rtl/sliding_window_event_rate_meter.sv
rtl/swrm_checker.sv
tb/sv/rate_meter_checker.sv
tb/sv/testbench.sv
